/* hdl/swtmr_pkg.sv */
// Shared types, constants and helper functions for the software timer bank.
package swtmr_pkg;

	localparam int NUM_TIMERS_DEF = 8;
	localparam int NUM_SLOTS_DEF  = 4;
	localparam int CNT_W          = 31;
	localparam int VAL_W          = 32;
	localparam int IDX_W          = 4;
	localparam int DELAY_W        = 16;
	localparam int PERIOD_W       = 8;
	localparam int MASK_W         = 4;

	typedef enum logic [2:0] {
		CMD_TICK     = 3'd0,
		CMD_SET      = 3'd1,
		CMD_QUERY    = 3'd2,
		CMD_DELAY    = 3'd3,
		CMD_ADD_SLOT = 3'd4
	} cmd_t;

	typedef struct packed {
		logic             tick;
		logic             set;
		logic             query;
		logic [IDX_W-1:0] index;
	} tmr_op_t;

	// |v| saturated to 31 bits
	function automatic logic [CNT_W-1:0] magnitude(input logic [VAL_W-1:0] v);
		logic [VAL_W-1:0] n;
		n = v[VAL_W-1] ? (~v + VAL_W'(1)) : v;
		if (n[VAL_W-1])
			return '1;
		return n[CNT_W-1:0];
	endfunction

	function automatic logic [DELAY_W-1:0] clamp_delay(input logic [VAL_W-1:0] v);
		if (v[VAL_W-1])
			return '0;
		if (|v[VAL_W-2:DELAY_W])
			return '1;
		return v[DELAY_W-1:0];
	endfunction

	function automatic logic [PERIOD_W-1:0] clamp_period(input logic [VAL_W-1:0] v);
		if (v[VAL_W-1])
			return '0;
		if (|v[VAL_W-2:PERIOD_W])
			return '1;
		return v[PERIOD_W-1:0];
	endfunction

endpackage

/* hdl/swtmr_timers.sv */
// Bank of countdown timers with optional re-arm on query.
module swtmr_timers import swtmr_pkg::*; #(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tmr_op_t          op,
	input  logic [VAL_W-1:0] value,
	output logic             finished,
	output logic             rejected
);

	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	logic [CNT_W-1:0] count_q      [NUM_TIMERS];
	logic [CNT_W-1:0] reload_mag_q [NUM_TIMERS];
	logic             reload_neg_q [NUM_TIMERS];

	logic          in_range;
	logic [IW-1:0] sel;
	logic          rd_zero;
	logic [CNT_W-1:0] load_mag;

	assign in_range = {1'b0, op.index} < (IDX_W + 1)'(NUM_TIMERS);
	assign sel      = op.index[IW-1:0];
	assign load_mag = magnitude(value);
	assign rd_zero  = in_range && (count_q[sel] == '0);

	assign finished = op.query && rd_zero;
	assign rejected = (op.set || op.query) && !in_range;

	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_tmr
		logic hit;
		assign hit = in_range && (sel == IW'(i));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				count_q[i]      <= '0;
				reload_mag_q[i] <= '0;
				reload_neg_q[i] <= 1'b0;
			end else if (op.tick) begin
				if (count_q[i] != '0)
					count_q[i] <= count_q[i] - CNT_W'(1);
			end else if (op.set && hit) begin
				count_q[i]      <= load_mag;
				reload_mag_q[i] <= load_mag;
				reload_neg_q[i] <= value[VAL_W-1];
			end else if (op.query && hit && count_q[i] == '0 && reload_neg_q[i]) begin
				count_q[i] <= reload_mag_q[i];
			end
		end
	end

endmodule

/* hdl/swtmr_slots.sv */
// Periodic event slots: fire and reload on tick, installed in order.
module swtmr_slots import swtmr_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick,
	input  logic                add,
	input  logic [PERIOD_W-1:0] period,
	output logic [NUM_SLOTS-1:0] fired,
	output logic                rejected
);

	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int UW = $clog2(NUM_SLOTS + 1);

	logic [PERIOD_W-1:0] period_q [NUM_SLOTS];
	logic [PERIOD_W-1:0] count_q  [NUM_SLOTS];
	logic [UW-1:0]       used_q;
	logic                full;

	assign full     = used_q >= UW'(NUM_SLOTS);
	assign rejected = add && full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			used_q <= '0;
		else if (add && !full)
			used_q <= used_q + UW'(1);
	end

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_slot
		logic active;
		logic wr;
		assign active   = UW'(i) < used_q;
		assign wr       = add && !full && (used_q[SW-1:0] == SW'(i));
		assign fired[i] = tick && active && (count_q[i] == '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				period_q[i] <= '0;
				count_q[i]  <= '0;
			end else if (tick && active) begin
				if (count_q[i] == '0)
					count_q[i] <= period_q[i];
				else
					count_q[i] <= count_q[i] - PERIOD_W'(1);
			end else if (wr) begin
				period_q[i] <= period;
				count_q[i]  <= period;
			end
		end
	end

endmodule

/* hdl/software_timer_bank.sv */
// Top level of the software timer bank: input register, command decode, result register.
//
// Usage: one command per input transaction (command, index, value); every
// command yields exactly one result transaction (finished, delay_active,
// fired_mask, rejected). Both channels use valid/stall handshakes.
// Order: a command is registered at the input, executed against the timer,
// delay and slot state once the output register is free, and its result is
// presented from the output register.
// Throughput: one command per cycle unless stalled; every counter is updated
// in parallel by one level of logic between the input and the result register.
// Reset: arst_n clears all counts, reload values, periods and the slot fill
// count, and empties both pipeline registers.
// Stall: while out_stall holds a result, the command waiting in the input
// register stays there and in_stall rises; no state changes until the
// result is taken.
module software_timer_bank import swtmr_pkg::*; #(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF,
	parameter int NUM_SLOTS  = NUM_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        command,
	input  logic [IDX_W-1:0]  index,
	input  logic signed [VAL_W-1:0] value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              finished,
	output logic              delay_active,
	output logic [MASK_W-1:0] fired_mask,
	output logic              rejected
);

	logic              valid_s1;
	logic [2:0]        command_s1;
	logic [IDX_W-1:0]  index_s1;
	logic [VAL_W-1:0]  value_s1;

	logic              valid_s2;
	logic              finished_s2;
	logic [MASK_W-1:0] fired_s2;
	logic              rejected_s2;

	logic [DELAY_W-1:0] delay_q;

	logic out_free;
	logic exec;
	logic accept;

	tmr_op_t        tmr_op;
	logic           add_slot;
	logic           set_delay;
	logic           tmr_finished;
	logic           tmr_rejected;
	logic [NUM_SLOTS-1:0] slot_fired;
	logic           slot_rejected;

	assign out_free = !valid_s2 || !out_stall;
	assign exec     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (exec)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			command_s1 <= command;
			index_s1   <= index;
			value_s1   <= value;
		end
	end

	always_comb begin
		tmr_op       = '0;
		tmr_op.index = index_s1;
		add_slot     = 1'b0;
		set_delay    = 1'b0;
		if (exec) begin
			case (command_s1)
				CMD_TICK:     tmr_op.tick  = 1'b1;
				CMD_SET:      tmr_op.set   = 1'b1;
				CMD_QUERY:    tmr_op.query = 1'b1;
				CMD_DELAY:    set_delay    = 1'b1;
				CMD_ADD_SLOT: add_slot     = 1'b1;
				default:      ;
			endcase
		end
	end

	swtmr_timers #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_timers (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (tmr_op),
		.value    (value_s1),
		.finished (tmr_finished),
		.rejected (tmr_rejected)
	);

	swtmr_slots #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_slots (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tmr_op.tick),
		.add      (add_slot),
		.period   (clamp_period(value_s1)),
		.fired    (slot_fired),
		.rejected (slot_rejected)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= '0;
		end else if (set_delay) begin
			delay_q <= clamp_delay(value_s1);
		end else if (tmr_op.tick && delay_q != '0) begin
			delay_q <= delay_q - DELAY_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (out_free)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			finished_s2 <= tmr_finished;
			fired_s2    <= MASK_W'(slot_fired);
			rejected_s2 <= tmr_rejected || slot_rejected;
		end
	end

	// delay_q already holds the post-command value while the result waits
	assign out_valid    = valid_s2;
	assign finished     = finished_s2;
	assign delay_active = delay_q != '0;
	assign fired_mask   = fired_s2;
	assign rejected     = rejected_s2;

endmodule
